### rtl/core/r2fft_pkg.sv
package r2fft_pkg;

    localparam int STAGE_SIZE  = 64;
    localparam int HALF_SIZE   = STAGE_SIZE / 2;
    localparam int STORE_DEPTH = 32;
    localparam int ROM_POINTS  = 64;
    localparam int SLOT_W      = $clog2(STORE_DEPTH);
    localparam int WORD_W      = 32;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HALF_SIZE - 1);

    typedef enum logic [1:0] {
        CMD_FILL      = 2'd0,
        CMD_BFLY      = 2'd1,
        CMD_BFLY_LAST = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [SLOT_W-1:0]  slot;
        logic signed [15:0] re;
        logic signed [15:0] im;
    } cmd_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } store_req_t;

    typedef logic [SLOT_W-1:0] tw_idx_tab_t [STORE_DEPTH];

    function automatic tw_idx_tab_t make_tw_idx();
        tw_idx_tab_t t;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            t[i] = SLOT_W'((i * ROM_POINTS) / STAGE_SIZE);
        end
        return t;
    endfunction

    // ROM index per slot: k * 64 / N
    localparam tw_idx_tab_t TW_IDX = make_tw_idx();

    // cos(2*pi*i/64), i = 0..16, Q1.15
    localparam logic signed [15:0] QCOS [17] = '{
        16'sd32767, 16'sd32610, 16'sd32138, 16'sd31357, 16'sd30274, 16'sd28899,
        16'sd27246, 16'sd25330, 16'sd23170, 16'sd20788, 16'sd18205, 16'sd15447,
        16'sd12540, 16'sd9512,  16'sd6393,  16'sd3212,  16'sd0
    };

    function automatic logic signed [15:0] tw_cos(logic [SLOT_W-1:0] k);
        logic [SLOT_W-1:0] ri;
        ri = TW_IDX[k];
        if (ri <= 5'd16)
            return QCOS[ri];
        else
            return 16'(-QCOS[5'(6'd32 - {1'b0, ri})]);
    endfunction

    function automatic logic signed [15:0] tw_sin(logic [SLOT_W-1:0] k);
        logic [SLOT_W-1:0] ri;
        ri = TW_IDX[k];
        if (ri <= 5'd16)
            return QCOS[5'(5'd16 - ri)];
        else
            return QCOS[5'(ri - 5'd16)];
    endfunction

    function automatic logic signed [15:0] sat16(logic signed [16:0] v);
        if (v[16] != v[15])
            return v[16] ? 16'sh8000 : 16'sh7fff;
        else
            return v[15:0];
    endfunction

    // round half up of v / 2^15, then saturate
    function automatic logic signed [15:0] round_q15(logic signed [32:0] v);
        logic signed [32:0] b;
        logic signed [17:0] q;
        b = v + 33'sd16384;
        q = 18'(b >>> 15);
        if (q > 18'sd32767)
            return 16'sh7fff;
        else if (q < -18'sd32768)
            return 16'sh8000;
        else
            return q[15:0];
    endfunction

endpackage

### rtl/core/r2fft_ram.sv
module r2fft_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/r2fft_front.sv
module r2fft_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic signed [15:0]   sample_re,
    input  logic signed [15:0]   sample_im,
    output logic                 cmd_valid,
    output r2fft_pkg::cmd_t      cmd,
    input  logic                 cmd_pop
);

    logic                           phase_reg, phase_next;
    logic [r2fft_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [1:0]                     cnt_reg, cnt_next;
    r2fft_pkg::cmd_t                q_reg [2];
    r2fft_pkg::cmd_t                q_next [2];
    r2fft_pkg::cmd_t                cmd_in;
    logic                           accept;
    logic [1:0]                     wpos;

    assign full      = (cnt_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[0];

    always_comb
    begin
        cmd_in.slot = slot_reg;
        cmd_in.re   = sample_re;
        cmd_in.im   = sample_im;
        if (!phase_reg)
            cmd_in.kind = r2fft_pkg::CMD_FILL;
        else if (slot_reg == r2fft_pkg::LAST_SLOT)
            cmd_in.kind = r2fft_pkg::CMD_BFLY_LAST;
        else
            cmd_in.kind = r2fft_pkg::CMD_BFLY;
    end

    always_comb
    begin
        phase_next = phase_reg;
        slot_next  = slot_reg;
        if (accept)
        begin
            if (slot_reg == r2fft_pkg::LAST_SLOT)
            begin
                phase_next = !phase_reg;
                slot_next  = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        q_next   = q_reg;
        cnt_next = cnt_reg + {1'b0, accept} - {1'b0, cmd_pop};
        wpos     = cnt_reg - {1'b0, cmd_pop};
        if (cmd_pop)
            q_next[0] = q_reg[1];
        if (accept)
            q_next[wpos[0]] = cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            slot_reg  <= '0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

### rtl/core/r2fft_back.sv
module r2fft_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  r2fft_pkg::cmd_t                     cmd,
    output logic                                cmd_pop,
    output r2fft_pkg::store_req_t               store_req,
    input  logic [r2fft_pkg::WORD_W-1:0]        store_rdata,
    input  logic                                res_pop,
    output logic                                res_empty,
    output logic signed [15:0]                  res_re,
    output logic signed [15:0]                  res_im,
    output logic                                res_tw,
    output logic                                res_last
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_BF     = 6'b000010,
        ST_TW_RD  = 6'b000100,
        ST_TW_M1  = 6'b001000,
        ST_TW_M2  = 6'b010000,
        ST_TW_OUT = 6'b100000
    } state_t;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               tw;
        logic               last;
    } res_t;

    state_t                         state_reg, state_next;
    logic [r2fft_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [r2fft_pkg::SLOT_W-1:0]   k_reg, k_next;
    logic                           blast_reg, blast_next;
    logic signed [15:0]             xr_reg, xr_next;
    logic signed [15:0]             xi_reg, xi_next;
    logic signed [15:0]             c_reg, s_reg;
    logic signed [31:0]             p_ac_reg, p_bs_reg, p_bc_reg, p_as_reg;
    logic [1:0]                     rcnt_reg, rcnt_next;
    res_t                           rq_reg [2];
    res_t                           rq_next [2];
    res_t                           res_in;
    logic                           res_push;
    logic                           res_space;
    logic [1:0]                     rwpos;
    logic signed [15:0]             pr, pi;
    logic signed [15:0]             sum_re, sum_im, dif_re, dif_im;

    assign pr = store_rdata[15:0];
    assign pi = store_rdata[31:16];

    assign sum_re = r2fft_pkg::sat16({pr[15], pr} + {xr_reg[15], xr_reg});
    assign sum_im = r2fft_pkg::sat16({pi[15], pi} + {xi_reg[15], xi_reg});
    assign dif_re = r2fft_pkg::sat16({pr[15], pr} - {xr_reg[15], xr_reg});
    assign dif_im = r2fft_pkg::sat16({pi[15], pi} - {xi_reg[15], xi_reg});

    assign res_space = (rcnt_reg != 2'd2);

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        k_next     = k_reg;
        blast_next = blast_reg;
        xr_next    = xr_reg;
        xi_next    = xi_reg;
        cmd_pop    = 1'b0;
        store_req  = '0;
        res_push   = 1'b0;
        res_in     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == r2fft_pkg::CMD_FILL)
                    begin
                        store_req.we    = 1'b1;
                        store_req.waddr = cmd.slot;
                        store_req.wdata = {cmd.im, cmd.re};
                    end
                    else
                    begin
                        store_req.re    = 1'b1;
                        store_req.raddr = cmd.slot;
                        slot_next       = cmd.slot;
                        xr_next         = cmd.re;
                        xi_next         = cmd.im;
                        blast_next      = (cmd.kind == r2fft_pkg::CMD_BFLY_LAST);
                        state_next      = ST_BF;
                    end
                end
            end
            ST_BF:
            begin
                if (res_space)
                begin
                    store_req.we    = 1'b1;
                    store_req.waddr = slot_reg;
                    store_req.wdata = {dif_im, dif_re};
                    res_push        = 1'b1;
                    res_in          = '{re: sum_re, im: sum_im, tw: 1'b0, last: !blast_reg};
                    k_next          = '0;
                    state_next      = blast_reg ? ST_TW_RD : ST_IDLE;
                end
            end
            ST_TW_RD:
            begin
                store_req.re    = 1'b1;
                store_req.raddr = k_reg;
                state_next      = ST_TW_M1;
            end
            ST_TW_M1:
            begin
                state_next = ST_TW_M2;
            end
            ST_TW_M2:
            begin
                state_next = ST_TW_OUT;
            end
            ST_TW_OUT:
            begin
                if (res_space)
                begin
                    res_push = 1'b1;
                    res_in.re = r2fft_pkg::round_q15({p_ac_reg[31], p_ac_reg}
                                                     + {p_bs_reg[31], p_bs_reg});
                    res_in.im = r2fft_pkg::round_q15({p_bc_reg[31], p_bc_reg}
                                                     - {p_as_reg[31], p_as_reg});
                    res_in.tw   = 1'b1;
                    res_in.last = (k_reg == r2fft_pkg::LAST_SLOT);
                    if (k_reg == r2fft_pkg::LAST_SLOT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_TW_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rq_next   = rq_reg;
        rcnt_next = rcnt_reg + {1'b0, res_push} - {1'b0, res_pop};
        rwpos     = rcnt_reg - {1'b0, res_pop};
        if (res_pop)
            rq_next[0] = rq_reg[1];
        if (res_push)
            rq_next[rwpos[0]] = res_in;
    end

    assign res_empty = (rcnt_reg == 2'd0);
    assign res_re    = rq_reg[0].re;
    assign res_im    = rq_reg[0].im;
    assign res_tw    = rq_reg[0].tw;
    assign res_last  = rq_reg[0].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            rcnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg  <= slot_next;
        blast_reg <= blast_next;
        xr_reg    <= xr_next;
        xi_reg    <= xi_next;
        rq_reg    <= rq_next;
        if (state_reg == ST_TW_RD)
        begin
            c_reg <= r2fft_pkg::tw_cos(k_reg);
            s_reg <= r2fft_pkg::tw_sin(k_reg);
        end
        if (state_reg == ST_TW_M1)
        begin
            p_ac_reg <= pr * c_reg;
            p_bs_reg <= pi * s_reg;
        end
        if (state_reg == ST_TW_M2)
        begin
            p_bc_reg <= pi * c_reg;
            p_as_reg <= pr * s_reg;
        end
    end

endmodule

### rtl/core/radix2_dif_fft_stage_core.sv
// channel   signals                                   word
// input     push, full, sample_re, sample_im          one complex sample
// result    pop, empty, result_re, result_im,         sum or twiddled difference
//           is_twiddled, last
//
// Fill sample: store write. Butterfly sample: store read, then write-back.
// Per twiddled word (N/2 after a frame's last sample): ST_TW_RD, ST_TW_M1, ST_TW_M2,
// ST_TW_OUT, set by the two-multiplier sequence on the single delay-store read port.
// Reset clears queues and sequencer; the delay store is not cleared.
// A 2-word command queue and a 2-word result queue let input and output stall apart.
module radix2_dif_fft_stage_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [15:0]  sample_re,
    input  logic signed [15:0]  sample_im,
    output logic                empty,
    input  logic                pop,
    output logic signed [15:0]  result_re,
    output logic signed [15:0]  result_im,
    output logic                is_twiddled,
    output logic                last
);

    logic                                cmd_valid;
    r2fft_pkg::cmd_t                     cmd;
    logic                                cmd_pop;
    r2fft_pkg::store_req_t               store_req;
    logic [r2fft_pkg::WORD_W-1:0]        store_rdata;
    logic                                res_pop;

    assign res_pop = pop && !empty;

    r2fft_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .sample_re (sample_re),
        .sample_im (sample_im),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    r2fft_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .store_req   (store_req),
        .store_rdata (store_rdata),
        .res_pop     (res_pop),
        .res_empty   (empty),
        .res_re      (result_re),
        .res_im      (result_im),
        .res_tw      (is_twiddled),
        .res_last    (last)
    );

    r2fft_ram #(
        .WIDTH (r2fft_pkg::WORD_W),
        .DEPTH (r2fft_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_req.we),
        .waddr (store_req.waddr),
        .wdata (store_req.wdata),
        .re    (store_req.re),
        .raddr (store_req.raddr),
        .rdata (store_rdata)
    );

endmodule
